// ----- rtl/rtp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types, fixed widths, constants and the arctangent table of the
// rotating tidal potential datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

    // field widths fixed by the item and register formats
    localparam int TIME_W    = 32;
    localparam int SPEED_W   = 32;
    localparam int GRAV_W    = 31;
    localparam int RAD_W     = 31;
    localparam int RES_W     = 64;
    localparam int R3_W      = 3 * RAD_W;

    // datapath constants
    localparam int MUL_DIGIT  = 16;     // multiplier operand bits per cell
    localparam int TRIG_W     = 34;     // cordic datapath width, Q4.30 values
    localparam int TRIG_SHIFT = 60;     // base scaled to the Q.60 of proj^2
    localparam int QUO_SHIFT  = 29;     // 2^61 / 2^32 folded into the dividend
    localparam int ANG_W      = 32;     // binary angle, 2^32 per turn

    localparam logic [30:0] INV_TWO_PI_TURNS = 31'd683565276;

    localparam logic signed [TRIG_W-1:0] CORDIC_START   = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] CORDIC_ONE     = 34'sd1073741824;
    localparam logic signed [TRIG_W-1:0] CORDIC_QUARTER = 34'sd1073741824;
    localparam logic signed [TRIG_W-1:0] CORDIC_HALF    = 34'sd2147483648;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CENTER_X   = 4'd0;
    localparam t_cfg_idx CFG_CENTER_Y   = 4'd1;
    localparam t_cfg_idx CFG_CENTER_Z   = 4'd2;
    localparam t_cfg_idx CFG_GRAV_MASS  = 4'd3;
    localparam t_cfg_idx CFG_ORBIT_RAD  = 4'd4;
    localparam t_cfg_idx CFG_ORBIT_SPD  = 4'd5;
    localparam t_cfg_idx CFG_FIXED_POS  = 4'd6;
    localparam t_cfg_idx CFG_CENTRIFUGE = 4'd7;

    // atan(2^-i) in binary angle units
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rotating_tidal_potential.sv -----
// ----------------------------------------------------------------------------
// rotating_tidal_potential
// Quadrupole tidal potential of an orbiting host around a satellite centre,
// one item per clock through rows of multiplier, divider and cordic cells.
// ----------------------------------------------------------------------------
// throughput: one item per clock, set by the fully pipelined cell rows
//   (two 64-cell divider rows dominate the latency)
// reset: clears the valid pipe and the configuration registers to their reset values;
//   no clearing pass, an item may start right after reset
`default_nettype none

module rotating_tidal_potential #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  wire logic [rtp_pkg::TIME_W-1:0]    i_sim_time,

    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire rtp_pkg::t_cfg_idx             i_cfg_index,
    input  wire logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] i_cfg_data,

    output logic                               o_valid,
    output logic signed [rtp_pkg::RES_W-1:0]   o_potential,
    output logic                               o_saturated
);

    localparam int CW   = COORD_WIDTH;
    localparam int DWD  = CW + 1;
    localparam int DG   = rtp_pkg::MUL_DIGIT;
    localparam int TW   = rtp_pkg::TRIG_W;
    localparam int RW   = rtp_pkg::RES_W;
    localparam int QB   = FRAC_BITS + rtp_pkg::ANG_W;

    localparam int L_M1  = (rtp_pkg::SPEED_W + 1 + DG - 1) / DG;
    localparam int L_D   = RW;
    localparam int L_M2  = (31 + DG - 1) / DG;
    localparam int L_COR = CORDIC_STAGES + 1;
    localparam int LA    = L_M1 + L_D + L_M2 + L_COR;
    localparam int L_SQ  = (DWD + DG - 1) / DG;
    localparam int L_P1  = (TW + DG - 1) / DG;
    localparam int PW    = DWD + TW + 1;
    localparam int L_P2  = (PW + DG - 1) / DG;
    localparam int QWD   = 2 * PW + 3;
    localparam int L_M3  = (QWD + DG - 1) / DG;
    localparam int M3W   = QWD + rtp_pkg::GRAV_W + 1;
    localparam int WP    = M3W - rtp_pkg::QUO_SHIFT;
    localparam int HW    = WP - RW;
    localparam int R3W   = rtp_pkg::R3_W;
    localparam int CMPW  = (HW > R3W) ? HW : R3W;
    localparam int N_B   = LA + L_P1 + 1 + L_P2 - L_SQ;
    localparam int LT    = 1 + LA + L_P1 + 1 + L_P2 + 1 + L_M3 + 1 + L_D + 1;

    localparam logic [RW-1:0] POS_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic [RW-1:0] NEG_MIN = {1'b1, {(RW-1){1'b0}}};

    // configuration registers
    logic signed [CW-1:0]                 r_cx, r_cy, r_cz;
    logic [rtp_pkg::GRAV_W-1:0]           r_grav;
    logic [rtp_pkg::RAD_W-1:0]            r_rad;
    logic signed [rtp_pkg::SPEED_W-1:0]   r_speed;
    logic                                 r_fixed;
    logic                                 r_centri;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_grav   <= '0;
            r_rad    <= 31'd65536;
            r_speed  <= '0;
            r_fixed  <= 1'b0;
            r_centri <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rtp_pkg::CFG_CENTER_X:   r_cx     <= $signed(i_cfg_data[CW-1:0]);
                rtp_pkg::CFG_CENTER_Y:   r_cy     <= $signed(i_cfg_data[CW-1:0]);
                rtp_pkg::CFG_CENTER_Z:   r_cz     <= $signed(i_cfg_data[CW-1:0]);
                rtp_pkg::CFG_GRAV_MASS:  r_grav   <= i_cfg_data[rtp_pkg::GRAV_W-1:0];
                rtp_pkg::CFG_ORBIT_RAD:  r_rad    <= i_cfg_data[rtp_pkg::RAD_W-1:0];
                rtp_pkg::CFG_ORBIT_SPD:  r_speed  <= $signed(i_cfg_data[31:0]);
                rtp_pkg::CFG_FIXED_POS:  r_fixed  <= i_cfg_data[0];
                rtp_pkg::CFG_CENTRIFUGE: r_centri <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero radius acts as the smallest step
    logic [rtp_pkg::RAD_W-1:0]   w_rr;
    logic [rtp_pkg::SPEED_W-1:0] w_vm;
    assign w_rr = (r_rad == '0) ? 31'd1 : r_rad;
    assign w_vm = r_speed[rtp_pkg::SPEED_W-1] ? (32'd0 - r_speed) : r_speed;

    // r^3, follows the radius register
    logic signed [63:0]  w_r2;
    logic signed [94:0]  w_r3p;
    logic [R3W-1:0]      w_r3;

    rtp_mul #(.AW(32), .BW(32)) u_r2 (
        .i_clk (i_clk),
        .i_a   ($signed({1'b0, w_rr})),
        .i_b   ($signed({1'b0, w_rr})),
        .o_p   (w_r2)
    );

    rtp_mul #(.AW(63), .BW(32)) u_r3 (
        .i_clk (i_clk),
        .i_a   ($signed({1'b0, w_r2[61:0]})),
        .i_b   ($signed({1'b0, w_rr})),
        .o_p   (w_r3p)
    );
    assign w_r3 = w_r3p[R3W-1:0];

    // valid pipe
    logic [LT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LT-2:0], i_start && !o_busy};
        end
    end
    assign o_valid = r_vld[LT-1];

    // entry stage
    logic signed [DWD-1:0]        r_dx, r_dy, r_dz;
    logic [rtp_pkg::TIME_W-1:0]   r_t;

    always_ff @(posedge i_clk) begin
        r_dx <= DWD'(i_pos_x) - DWD'(r_cx);
        r_dy <= DWD'(i_pos_y) - DWD'(r_cy);
        r_dz <= DWD'(i_pos_z) - DWD'(r_cz);
        r_t  <= i_sim_time;
    end

    // host angle: |v|*t / r, scaled to binary angle units
    logic signed [65:0]       w_m1;
    logic [RW-1:0]            w_qa;
    logic signed [QB+31:0]    w_m2;
    logic [31:0]              w_ang_raw;
    logic [31:0]              w_ang;
    logic signed [TW-1:0]     w_cos, w_sin;

    rtp_mul #(.AW(33), .BW(33)) u_vt (
        .i_clk (i_clk),
        .i_a   ($signed({1'b0, w_vm})),
        .i_b   ($signed({1'b0, r_t})),
        .o_p   (w_m1)
    );

    rtp_div #(.QW(RW), .DW(rtp_pkg::RAD_W)) u_adiv (
        .i_clk (i_clk),
        .i_rem ('0),
        .i_num (w_m1[RW-1:0]),
        .i_den (w_rr),
        .o_quo (w_qa)
    );

    rtp_mul #(.AW(QB+1), .BW(31)) u_turn (
        .i_clk (i_clk),
        .i_a   ($signed({1'b0, w_qa[QB-1:0]})),
        .i_b   ($signed(rtp_pkg::INV_TWO_PI_TURNS)),
        .o_p   (w_m2)
    );

    assign w_ang_raw = w_m2[FRAC_BITS+31:FRAC_BITS];
    assign w_ang = r_fixed ? 32'd0 :
                   (r_speed[rtp_pkg::SPEED_W-1] ? (32'd0 - w_ang_raw) : w_ang_raw);

    rtp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk (i_clk),
        .i_ang (w_ang),
        .o_cos (w_cos),
        .o_sin (w_sin)
    );

    // squared offsets
    logic signed [2*DWD-1:0] w_sx, w_sy, w_sz;
    logic [2*DWD-1:0]        w_base;
    logic [2*DWD-1:0]        w_base_d;

    rtp_mul #(.AW(DWD), .BW(DWD)) u_sx (
        .i_clk (i_clk), .i_a (r_dx), .i_b (r_dx), .o_p (w_sx)
    );
    rtp_mul #(.AW(DWD), .BW(DWD)) u_sy (
        .i_clk (i_clk), .i_a (r_dy), .i_b (r_dy), .o_p (w_sy)
    );
    rtp_mul #(.AW(DWD), .BW(DWD)) u_sz (
        .i_clk (i_clk), .i_a (r_dz), .i_b (r_dz), .o_p (w_sz)
    );

    // centrifugal mode leaves only the z term
    assign w_base = r_centri ? w_sz : (w_sx + w_sy + w_sz);

    rtp_dly #(.W(2*DWD), .N(N_B)) u_base_dly (
        .i_clk (i_clk), .i_d (w_base), .o_q (w_base_d)
    );

    // projection on the host direction
    logic [DWD-1:0]            w_dx_d, w_dy_d;
    logic signed [DWD+TW-1:0]  w_px, w_py;
    logic signed [PW-1:0]      r_proj;
    logic signed [2*PW-1:0]    w_proj2;

    rtp_dly #(.W(DWD), .N(LA)) u_dx_dly (.i_clk (i_clk), .i_d (r_dx), .o_q (w_dx_d));
    rtp_dly #(.W(DWD), .N(LA)) u_dy_dly (.i_clk (i_clk), .i_d (r_dy), .o_q (w_dy_d));

    rtp_mul #(.AW(DWD), .BW(TW)) u_px (
        .i_clk (i_clk), .i_a ($signed(w_dx_d)), .i_b (w_cos), .o_p (w_px)
    );
    rtp_mul #(.AW(DWD), .BW(TW)) u_py (
        .i_clk (i_clk), .i_a ($signed(w_dy_d)), .i_b (w_sin), .o_p (w_py)
    );

    always_ff @(posedge i_clk) begin
        r_proj <= PW'(w_px) + PW'(w_py);
    end

    rtp_mul #(.AW(PW), .BW(PW)) u_proj2 (
        .i_clk (i_clk), .i_a (r_proj), .i_b (r_proj), .o_p (w_proj2)
    );

    // q = base * 2^60 - 3 * proj^2
    logic signed [QWD-1:0] n_q;
    logic signed [QWD-1:0] n_three;
    logic signed [QWD-1:0] n_basex;
    logic [QWD-2:0]        r_qmag;
    logic                  r_qneg;

    always_comb begin
        n_three = QWD'(w_proj2) + (QWD'(w_proj2) <<< 1);
        n_basex = $signed(QWD'(w_base_d)) <<< rtp_pkg::TRIG_SHIFT;
        n_q     = n_basex - n_three;
    end

    always_ff @(posedge i_clk) begin
        r_qneg <= n_q[QWD-1];
        r_qmag <= n_q[QWD-1] ? (QWD-1)'(-n_q) : n_q[QWD-2:0];
    end

    // scale by GM, drop the fixed 2^29 of the divisor
    logic signed [M3W-1:0] w_m3;
    logic                  w_qneg_d;
    logic [WP-1:0]         w_p;
    logic [CMPW-1:0]       w_phi;

    // the wide magnitude walks the digit row so each cell stays narrow
    rtp_mul #(.AW(rtp_pkg::GRAV_W + 1), .BW(QWD)) u_gm (
        .i_clk (i_clk),
        .i_a   ($signed({1'b0, r_grav})),
        .i_b   ($signed({1'b0, r_qmag})),
        .o_p   (w_m3)
    );

    rtp_dly #(.W(1), .N(L_M3)) u_neg_dly (.i_clk (i_clk), .i_d (r_qneg), .o_q (w_qneg_d));

    assign w_p   = w_m3[M3W-1:rtp_pkg::QUO_SHIFT];
    assign w_phi = CMPW'(w_p[WP-1:RW]);

    // quotient needs more than 64 bits when the high part reaches r^3
    logic [R3W-1:0] r_prem;
    logic [RW-1:0]  r_plo;
    logic           r_ov;
    logic           r_neg2;

    always_ff @(posedge i_clk) begin
        r_prem <= w_phi[R3W-1:0];
        r_plo  <= w_p[RW-1:0];
        r_ov   <= (w_phi >= CMPW'(w_r3));
        r_neg2 <= w_qneg_d;
    end

    logic [RW-1:0] w_quo;
    logic [1:0]    w_flags_d;

    rtp_div #(.QW(RW), .DW(R3W)) u_pdiv (
        .i_clk (i_clk),
        .i_rem (r_prem),
        .i_num (r_plo),
        .i_den (w_r3),
        .o_quo (w_quo)
    );

    rtp_dly #(.W(2), .N(L_D)) u_flag_dly (
        .i_clk (i_clk), .i_d ({r_ov, r_neg2}), .o_q (w_flags_d)
    );

    // sign and saturation
    logic n_over;
    always_comb begin
        if (w_flags_d[0]) begin
            n_over = w_flags_d[1] || (w_quo > NEG_MIN);
        end else begin
            n_over = w_flags_d[1] || w_quo[RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_saturated <= n_over;
        if (n_over) begin
            o_potential <= w_flags_d[0] ? $signed(NEG_MIN) : $signed(POS_MAX);
        end else begin
            o_potential <= w_flags_d[0] ? $signed(RW'(0) - w_quo) : $signed(w_quo);
        end
    end

    // every accepted item comes out at the end of the valid pipe
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LT o_valid)
        else $error("item did not come out at the pipeline latency");

    // a clipped result sits at one of the two limits
    a_sat_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_potential == $signed(POS_MAX) || o_potential == $signed(NEG_MIN)))
        else $error("saturated result not at a limit");

endmodule

`default_nettype wire

// ----- rtl/rtp_dly.sv -----
// ----------------------------------------------------------------------------
// rtp_dly
// Fixed-length shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_dly #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);

    logic [W-1:0] r_sr [0:N-1];

    always_ff @(posedge i_clk) begin
        r_sr[0] <= i_d;
    end

    for (genvar k = 1; k < N; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            r_sr[k] <= r_sr[k-1];
        end
    end

    assign o_q = r_sr[N-1];

endmodule

`default_nettype wire

// ----- rtl/rtp_mul.sv -----
// ----------------------------------------------------------------------------
// rtp_mul
// Signed multiplier as a row of cells; each cell folds one digit of b into
// the running sum and hands a, the rest of b and the sum to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic               i_clk,
    input  wire logic signed [AW-1:0]    i_a,
    input  wire logic signed [BW-1:0]    i_b,
    output logic      signed [AW+BW-1:0] o_p
);

    localparam int DG  = rtp_pkg::MUL_DIGIT;
    localparam int ND  = (BW + DG - 1) / DG;
    localparam int BPW = ND * DG;
    localparam int ACW = AW + BPW + 1;

    logic signed [AW-1:0]  w_a   [0:ND-1];
    logic signed [BPW-1:0] w_b   [0:ND-1];
    logic signed [ACW-1:0] w_acc [0:ND-1];

    logic signed [AW-1:0]  r_a   [0:ND-2];
    logic signed [BPW-1:0] r_b   [0:ND-2];
    logic signed [ACW-1:0] r_acc [0:ND-1];

    assign w_a[0]   = i_a;
    assign w_b[0]   = BPW'(i_b);
    assign w_acc[0] = '0;

    for (genvar k = 0; k < ND; k++) begin : g_cell
        logic        [DG-1:0]   dig;
        logic signed [DG:0]     digs;
        logic signed [AW+DG:0]  pp;
        logic signed [ACW-1:0]  ppx;

        assign dig  = w_b[k][k*DG +: DG];
        // top digit carries the sign of b
        assign digs = (k == ND - 1) ? $signed({dig[DG-1], dig}) : $signed({1'b0, dig});
        assign pp   = w_a[k] * digs;
        assign ppx  = ACW'(pp);

        always_ff @(posedge i_clk) begin
            r_acc[k] <= w_acc[k] + (ppx <<< (k * DG));
        end

        if (k < ND - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                r_a[k] <= w_a[k];
                r_b[k] <= w_b[k];
            end
            assign w_a[k+1]   = r_a[k];
            assign w_b[k+1]   = r_b[k];
            assign w_acc[k+1] = r_acc[k];
        end
    end

    assign o_p = r_acc[ND-1][AW+BW-1:0];

endmodule

`default_nettype wire

// ----- rtl/rtp_div.sv -----
// ----------------------------------------------------------------------------
// rtp_div
// Restoring divider as a row of cells, one quotient bit per cell. The
// starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_div #(
    parameter int QW = 64,
    parameter int DW = 31
) (
    input  wire logic          i_clk,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    logic [DW-1:0] w_rem [0:QW-1];
    logic [QW-1:0] w_num [0:QW-1];
    logic [DW-1:0] w_den [0:QW-1];

    logic [DW-1:0] r_rem [0:QW-2];
    logic [DW-1:0] r_den [0:QW-2];
    logic [QW-1:0] r_num [0:QW-1];

    assign w_rem[0] = i_rem;
    assign w_num[0] = i_num;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        logic [DW:0] rem2;
        logic [DW:0] diff;
        logic        ge;

        assign rem2 = {w_rem[k], w_num[k][QW-1]};
        assign diff = rem2 - {1'b0, w_den[k]};
        assign ge   = (rem2 >= {1'b0, w_den[k]});

        // quotient bits shift in where dividend bits leave
        always_ff @(posedge i_clk) begin
            r_num[k] <= {w_num[k][QW-2:0], ge};
        end

        if (k < QW - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                r_rem[k] <= ge ? diff[DW-1:0] : rem2[DW-1:0];
                r_den[k] <= w_den[k];
            end
            assign w_rem[k+1] = r_rem[k];
            assign w_num[k+1] = r_num[k];
            assign w_den[k+1] = r_den[k];
        end
    end

    assign o_quo = r_num[QW-1];

endmodule

`default_nettype wire

// ----- rtl/rtp_cordic.sv -----
// ----------------------------------------------------------------------------
// rtp_cordic
// Rotation-mode cordic: a fold stage into +-90 degrees, then one cell per
// micro-rotation, then the half-turn sign fix.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_cordic #(
    parameter int STAGES = 24
) (
    input  wire logic                          i_clk,
    input  wire logic [rtp_pkg::ANG_W-1:0]     i_ang,
    output logic signed [rtp_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [rtp_pkg::TRIG_W-1:0]  o_sin
);

    localparam int TW = rtp_pkg::TRIG_W;

    logic signed [TW-1:0] r_x [0:STAGES];
    logic signed [TW-1:0] r_y [0:STAGES];
    logic signed [TW-1:0] r_z [0:STAGES];
    logic                 r_flip [0:STAGES];
    logic                 r_zero [0:STAGES];

    logic signed [TW-1:0] n_z;
    logic                 n_flip;

    always_comb begin
        n_z    = TW'($signed(i_ang));
        n_flip = 1'b0;
        if (n_z > rtp_pkg::CORDIC_QUARTER) begin
            n_z    = n_z - rtp_pkg::CORDIC_HALF;
            n_flip = 1'b1;
        end else if (n_z < -rtp_pkg::CORDIC_QUARTER) begin
            n_z    = n_z + rtp_pkg::CORDIC_HALF;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= rtp_pkg::CORDIC_START;
        r_y[0]    <= '0;
        r_z[0]    <= n_z;
        r_flip[0] <= n_flip;
        r_zero[0] <= (i_ang == '0);
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        logic signed [TW-1:0] xs;
        logic signed [TW-1:0] ys;
        logic signed [TW-1:0] a;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign a  = $signed(TW'(rtp_pkg::atan_turn(5'(i))));

        always_ff @(posedge i_clk) begin
            if (!r_z[i][TW-1]) begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - a;
            end else begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + a;
            end
            r_flip[i+1] <= r_flip[i];
            r_zero[i+1] <= r_zero[i];
        end
    end

    // angle zero is exact: cos one, sin zero
    assign o_cos = r_zero[STAGES] ? rtp_pkg::CORDIC_ONE :
                   (r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES]);
    assign o_sin = r_zero[STAGES] ? '0 :
                   (r_flip[STAGES] ? -r_y[STAGES] : r_y[STAGES]);

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rotating_tidal_potential: random and directed cell
// items under several register settings, each result checked in order against
// a bit-exact predictor of the fixed-point tidal potential.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic signed [63:0] potential;
    logic               saturated;
} t_tide_res;

class t_tide_scoreboard;
    t_tide_res pending[$];
    int        mismatches;

    function new();
        mismatches = 0;
    endfunction

    function void note_item(t_tide_res exp_res);
        pending.push_back(exp_res);
    endfunction

    function void check_result(logic signed [63:0] pot, logic sat);
        t_tide_res e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: potential %h saturated %b", pot, sat);
            return;
        end
        e = pending.pop_front();
        if (e.potential !== pot || e.saturated !== sat) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected potential %h sat %b, got %h sat %b",
                         e.potential, e.saturated, pot, sat);
        end
    endfunction
endclass

module tb;

    localparam int  STAGES    = 24;
    localparam int  WDOG_MAX  = 3000;
    localparam int  DRAIN     = 200;
    localparam rtp_pkg::t_cfg_idx CFG_UNLISTED = 4'd11;
    localparam logic [31:0] ATAN_TBL [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [31:0]        i_sim_time = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    rtp_pkg::t_cfg_idx  i_cfg_index = rtp_pkg::CFG_CENTER_X;
    logic [31:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [63:0] o_potential;
    logic               o_saturated;

    rotating_tidal_potential i_dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor copy of the registers
    longint      ctr_x, ctr_y, ctr_z, spd;
    logic [63:0] gmass, orad;
    logic        hold_host, centri;

    t_tide_scoreboard sb = new();
    int idle_cycles = 0;

    function automatic t_tide_res tidal_potential(logic signed [31:0] px,
            logic signed [31:0] py, logic signed [31:0] pz, logic [31:0] tm);
        t_tide_res res;
        longint dx, dy, dz, x, y, z, xs, ys, cs, sn;
        logic [63:0] vm, rr, qa, prod;
        logic [31:0] ang;
        logic flip;
        logic signed [255:0] bx, by, bz, x2, y2, base, proj, q, wc, wsn;
        logic [255:0] mq, num, den, quo, r3;
        logic neg, over;
        dx = longint'(px) - ctr_x;
        dy = longint'(py) - ctr_y;
        dz = longint'(pz) - ctr_z;
        rr = (orad == 0) ? 64'd1 : orad;
        ang = '0;
        if (!hold_host) begin
            vm = (spd < 0) ? -spd : spd;
            qa = (vm * {32'd0, tm}) / rr;
            prod = qa * 64'd683565276;
            ang = prod[47:16];
            if (spd < 0)
                ang = -ang;
        end
        if (ang == 0) begin
            cs = longint'(1) << 30;
            sn = 0;
        end else begin
            z = {32'd0, ang};
            flip = 1'b0;
            if (z >= (longint'(1) << 31))
                z -= longint'(1) << 32;
            if (z > (longint'(1) << 30)) begin
                z -= longint'(1) << 31;
                flip = 1'b1;
            end else if (z < -(longint'(1) << 30)) begin
                z += longint'(1) << 31;
                flip = 1'b1;
            end
            x = 652032874;
            y = 0;
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(ATAN_TBL[i]);
                end else begin
                    x += ys; y -= xs; z += longint'(ATAN_TBL[i]);
                end
            end
            cs = flip ? -x : x;
            sn = flip ? -y : y;
        end
        bx = dx; by = dy; bz = dz; wc = cs; wsn = sn;
        x2 = bx * bx;
        y2 = by * by;
        base = x2 + y2 + bz * bz;
        if (centri)
            base = base - (x2 + y2);
        proj = bx * wc + by * wsn;
        q = (base <<< 60) - proj * proj * 256'sd3;
        neg = q[255];
        mq = neg ? -q : q;
        num = (mq * {192'd0, gmass}) << 32;
        r3 = {192'd0, rr} * {192'd0, rr} * {192'd0, rr};
        den = r3 << 61;
        quo = num / den;
        if (neg) begin
            over = (|quo[255:64]) || quo[63:0] > 64'h8000000000000000;
            res.potential = over ? 64'h8000000000000000 : -quo[63:0];
        end else begin
            over = (|quo[255:64]) || quo[63:0] > 64'h7FFFFFFFFFFFFFFF;
            res.potential = over ? 64'h7FFFFFFFFFFFFFFF : quo[63:0];
        end
        res.saturated = over;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_potential, o_saturated);
    end

    // watchdog on cycles with no accepted item, register write or result
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic send_cell(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] tm, bit allow_gap);
        int g;
        i_start    <= 1'b1;
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_pos_z    <= pz;
        i_sim_time <= tm;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(tidal_potential(px, py, pz, tm));
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            i_start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic quiesce();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(rtp_pkg::t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rtp_pkg::CFG_CENTER_X:   ctr_x = longint'(signed'(val));
            rtp_pkg::CFG_CENTER_Y:   ctr_y = longint'(signed'(val));
            rtp_pkg::CFG_CENTER_Z:   ctr_z = longint'(signed'(val));
            rtp_pkg::CFG_GRAV_MASS:  gmass = {33'd0, val[30:0]};
            rtp_pkg::CFG_ORBIT_RAD:  orad  = {33'd0, val[30:0]};
            rtp_pkg::CFG_ORBIT_SPD:  spd   = longint'(signed'(val));
            rtp_pkg::CFG_FIXED_POS:  hold_host = val[0];
            rtp_pkg::CFG_CENTRIFUGE: centri = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly modest magnitudes so results stay in range, some full range
    function automatic logic [31:0] rand_word(bit wide);
        logic [31:0] v;
        v = $urandom;
        if (!wide)
            v = {{12{v[31]}}, v[19:0]};
        return v;
    endfunction

    task automatic random_settings(bit extreme);
        write_reg(rtp_pkg::CFG_CENTER_X, rand_word(extreme));
        write_reg(rtp_pkg::CFG_CENTER_Y, rand_word(extreme));
        write_reg(rtp_pkg::CFG_CENTER_Z, rand_word(extreme));
        write_reg(rtp_pkg::CFG_GRAV_MASS, extreme ? $urandom : $urandom_range(32'h40000, 1));
        write_reg(rtp_pkg::CFG_ORBIT_RAD,
                  extreme ? $urandom : $urandom_range(32'h4000000, 32'h10000));
        write_reg(rtp_pkg::CFG_ORBIT_SPD, $urandom);
        write_reg(rtp_pkg::CFG_FIXED_POS, $urandom_range(1));
        write_reg(rtp_pkg::CFG_CENTRIFUGE, $urandom_range(1));
    endtask

    task automatic random_cells(int n, bit wide);
        for (int k = 0; k < n; k++)
            send_cell(rand_word(wide | ($urandom_range(7) == 0)), rand_word(wide),
                      rand_word(wide), $urandom, 1'b1);
    endtask

    initial begin
        ctr_x = 0; ctr_y = 0; ctr_z = 0; gmass = 0; orad = 65536; spd = 0;
        hold_host = 1'b0; centri = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: zero mass gives zero everywhere
        send_cell(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 1'b0);
        quiesce();

        write_reg(rtp_pkg::CFG_GRAV_MASS, 32'h00010000);
        write_reg(rtp_pkg::CFG_ORBIT_SPD, 32'h00010000);
        send_cell(32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0);
        send_cell(32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h00010000, 1'b0);
        send_cell(32'h0, 32'h00010000, 32'h0, 32'h0001921F, 1'b0);
        send_cell(32'h0, 32'h0, 32'h00030000, 32'h0003243F, 1'b0);
        send_cell(32'hFFFFFFFF, 32'h00000001, 32'h0, 32'h0004B65F, 1'b0);
        quiesce();
        // extremes: saturation both ways, radius one and zero, full speed
        write_reg(rtp_pkg::CFG_ORBIT_RAD, 32'h1);
        write_reg(rtp_pkg::CFG_GRAV_MASS, 32'h7FFFFFFF);
        send_cell(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_cell(32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0);
        send_cell(32'h0, 32'h0, 32'h0, 32'h12345678, 1'b0);
        quiesce();
        write_reg(rtp_pkg::CFG_ORBIT_RAD, 32'h0);
        write_reg(rtp_pkg::CFG_ORBIT_SPD, 32'h80000000);
        write_reg(rtp_pkg::CFG_CENTER_X, 32'h7FFFFFFF);
        write_reg(rtp_pkg::CFG_CENTER_Y, 32'h80000000);
        write_reg(rtp_pkg::CFG_CENTER_Z, 32'h80000000);
        send_cell(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_cell(32'h00000001, 32'h00000002, 32'h00000003, 32'h00000001, 1'b0);
        quiesce();
        write_reg(rtp_pkg::CFG_ORBIT_RAD, 32'h7FFFFFFF);
        write_reg(rtp_pkg::CFG_ORBIT_SPD, 32'h7FFFFFFF);
        write_reg(rtp_pkg::CFG_FIXED_POS, 32'h1);
        write_reg(rtp_pkg::CFG_CENTRIFUGE, 32'h1);
        write_reg(CFG_UNLISTED, 32'hFFFFFFFF);
        send_cell(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_cell(32'h12345678, 32'h9ABCDEF0, 32'h0, 32'h0, 1'b0);
        quiesce();

        for (int ph = 0; ph < 8; ph++) begin
            random_settings(ph % 4 == 3);
            random_cells(100, ph % 4 == 3);
            quiesce();
        end

        repeat (DRAIN) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
